// ===== rtl/core/dlbs_pkg.sv =====
package dlbs_pkg;

    // command codes carried by an input beat
    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_TICK    = 2'd0;
    localparam t_cmd CMD_RESTART = 2'd1;
    localparam t_cmd CMD_RETIME  = 2'd2;

    // configuration register indexes
    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_MASTER_ENABLE = 3'd0;
    localparam t_reg_idx REG_ON_TIME_A     = 3'd1;
    localparam t_reg_idx REG_OFF_TIME_A    = 3'd2;
    localparam t_reg_idx REG_START_DELAY_A = 3'd3;
    localparam t_reg_idx REG_ON_TIME_B     = 3'd4;
    localparam t_reg_idx REG_OFF_TIME_B    = 3'd5;
    localparam t_reg_idx REG_START_DELAY_B = 3'd6;

    localparam int NUM_LEDS = 2;

endpackage

// ===== rtl/core/dlbs_in_if.sv =====
interface dlbs_in_if;
    import dlbs_pkg::*;

    logic valid;
    logic ready;
    t_cmd cmd;
    logic led_index;

    modport source (output valid, output cmd, output led_index, input ready);
    modport sink   (input valid, input cmd, input led_index, output ready);
endinterface

// ===== rtl/core/dlbs_out_if.sv =====
interface dlbs_out_if;
    logic valid;
    logic ready;
    logic led_a_on;
    logic led_b_on;

    modport source (output valid, output led_a_on, output led_b_on, input ready);
    modport sink   (input valid, input led_a_on, input led_b_on, output ready);
endinterface

// ===== rtl/core/dlbs_cfg_if.sv =====
interface dlbs_cfg_if #(
    parameter int DATA_W = 24
);
    import dlbs_pkg::*;

    logic              valid;
    logic              ready;
    t_reg_idx          index;
    logic [DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/dual_led_blink_scheduler.sv =====
// dual status led blink scheduler: two leds, each with its own on time, off time and
// start delay in millisecond ticks. an input beat carries a command (tick, restart of
// both leds, retime of one led) and yields exactly one output beat with both drive
// levels after that command. one beat is accepted every clock cycle; a new beat is
// taken in the same cycle the previous registered result is taken, so only a stalled
// output holds the input back. both countdowns are updated together by one subtract
// and compare per led between the state registers. the configuration channel is always
// ready and must be instantiated with DATA_W = TIME_BITS; the user must write it only
// while no command is in flight, unchecked by the block. a zero master enable
// forces both leds off, and the first command after re-enabling restarts both.
module dual_led_blink_scheduler #(
    parameter int TIME_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dlbs_in_if.sink   i_in,
    dlbs_out_if.source o_out,
    dlbs_cfg_if.sink  i_cfg
);
    import dlbs_pkg::*;

    // countdown carries one extra bit so that all ones marks an idle led
    localparam int TL_W = TIME_BITS + 1;
    localparam logic [TL_W-1:0] IDLE_COUNT = '1;

    // configuration
    logic                 r_master_enable;
    logic [TIME_BITS-1:0] r_on_time     [NUM_LEDS];
    logic [TIME_BITS-1:0] r_off_time    [NUM_LEDS];
    logic [TIME_BITS-1:0] r_start_delay [NUM_LEDS];

    // blink state
    logic [TL_W-1:0] r_time_left [NUM_LEDS];
    logic [TL_W-1:0] n_time_left [NUM_LEDS];
    logic [NUM_LEDS-1:0] r_level;
    logic [NUM_LEDS-1:0] n_level;
    logic r_restart_pending;
    logic n_restart_pending;

    // output register
    logic r_out_valid;
    logic r_led_a_on;
    logic r_led_b_on;

    logic in_acc;
    logic cfg_acc;
    logic [TL_W-1:0] elapsed;

    // input taken whenever the output register is empty or being drained
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid;

    assign o_out.valid    = r_out_valid;
    assign o_out.led_a_on = r_led_a_on;
    assign o_out.led_b_on = r_led_b_on;

    // a tick consumes one millisecond, any other command none
    assign elapsed = {{(TL_W-1){1'b0}}, (i_in.cmd == CMD_TICK)};

    always_comb begin
        n_time_left       = r_time_left;
        n_level           = r_level;
        n_restart_pending = r_restart_pending;

        if (in_acc) begin
            if (!r_master_enable) begin
                // disabled: force dark, restart on the first enabled beat
                n_level           = '0;
                n_restart_pending = 1'b1;
            end else begin
                // restart first, either pending or commanded
                if (r_restart_pending || i_in.cmd == CMD_RESTART) begin
                    for (int k = 0; k < NUM_LEDS; k++) begin
                        n_level[k]     = 1'b0;
                        n_time_left[k] = {1'b0, r_start_delay[k]};
                    end
                    n_restart_pending = 1'b0;
                end

                // retime wakes the named led even from a steady state
                if (i_in.cmd == CMD_RETIME) begin
                    n_time_left[i_in.led_index] = '0;
                end

                // countdown and phase action per led
                for (int k = 0; k < NUM_LEDS; k++) begin
                    if (n_time_left[k] != IDLE_COUNT) begin
                        if (n_time_left[k] > elapsed) begin
                            n_time_left[k] = n_time_left[k] - elapsed;
                        end else if (r_on_time[k] != '0 && r_off_time[k] != '0) begin
                            // blinking: toggle and load the length of the new phase
                            n_level[k]     = !n_level[k];
                            n_time_left[k] = n_level[k] ? {1'b0, r_on_time[k]}
                                                        : {1'b0, r_off_time[k]};
                        end else begin
                            // steady on or steady off, counting stops
                            n_level[k]     = (r_on_time[k] != '0);
                            n_time_left[k] = IDLE_COUNT;
                        end
                    end
                end
            end
        end

        // clearing the master enable arms a restart
        if (cfg_acc && i_cfg.index == REG_MASTER_ENABLE && !i_cfg.data[0]) begin
            n_restart_pending = 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_enable <= 1'b1;
            for (int k = 0; k < NUM_LEDS; k++) begin
                r_on_time[k]     <= '0;
                r_off_time[k]    <= '0;
                r_start_delay[k] <= '0;
            end
        end else if (cfg_acc) begin
            unique case (i_cfg.index)
                REG_MASTER_ENABLE: r_master_enable  <= i_cfg.data[0];
                REG_ON_TIME_A:     r_on_time[0]     <= i_cfg.data[TIME_BITS-1:0];
                REG_OFF_TIME_A:    r_off_time[0]    <= i_cfg.data[TIME_BITS-1:0];
                REG_START_DELAY_A: r_start_delay[0] <= i_cfg.data[TIME_BITS-1:0];
                REG_ON_TIME_B:     r_on_time[1]     <= i_cfg.data[TIME_BITS-1:0];
                REG_OFF_TIME_B:    r_off_time[1]    <= i_cfg.data[TIME_BITS-1:0];
                REG_START_DELAY_B: r_start_delay[1] <= i_cfg.data[TIME_BITS-1:0];
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // blink state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LEDS; k++) begin
                r_time_left[k] <= IDLE_COUNT;
            end
            r_level           <= '0;
            r_restart_pending <= 1'b1;
        end else begin
            r_time_left       <= n_time_left;
            r_level           <= n_level;
            r_restart_pending <= n_restart_pending;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_led_a_on <= n_level[0];
            r_led_b_on <= n_level[1];
        end
    end

    // every accepted beat yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out.valid)
        else $error("accepted beat produced no result");

    // disabled block shows both leds dark
    a_disabled_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !r_master_enable |=> !o_out.led_a_on && !o_out.led_b_on)
        else $error("led lit while master enable is clear");

    // disabled beat arms a restart
    a_disabled_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !r_master_enable |=> r_restart_pending)
        else $error("restart not armed after disabled beat");

    // enabled beat with no config write consumes any pending restart
    a_restart_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_master_enable && !cfg_acc |=> !r_restart_pending)
        else $error("pending restart survived an enabled beat");

endmodule
